@@ hw/rtl/pedestrian_traffic_light_controller_assert.svh @@
// Assertion macros for the pedestrian traffic light controller checks.
// Included by the checker file; no other dependencies.
`ifndef PEDESTRIAN_TRAFFIC_LIGHT_CONTROLLER_ASSERT_SVH
`define PEDESTRIAN_TRAFFIC_LIGHT_CONTROLLER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define PTLC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Expression must never be true outside reset.
`define PTLC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

@@ hw/rtl/ptlc_pkg.sv @@
// Shared types, constants and phase functions for the traffic light controller.
// No dependencies.
`timescale 1ns / 1ps

package ptlc_pkg;

  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [TICK_W-1:0] RESET_TICKS = TICK_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GREEN  = 3'd0,
    CFG_YELLOW = 3'd1,
    CFG_RED    = 3'd2,
    CFG_WALK   = 3'd3,
    CFG_BLINK  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_GREEN      = 3'd0,
    PH_YELLOW     = 3'd1,
    PH_RED        = 3'd2,
    PH_YELLOW_RET = 3'd3,
    PH_EXTEND     = 3'd4,
    PH_BLINK      = 3'd5,
    PH_WALK       = 3'd6,
    PH_BLINK_BACK = 3'd7
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] green;
    logic [TICK_W-1:0] yellow;
    logic [TICK_W-1:0] red;
    logic [TICK_W-1:0] walk;
    logic [TICK_W-1:0] blink;
  } ptlc_cfg_t;

  typedef struct packed {
    logic   car_green;
    logic   car_yellow;
    logic   car_red;
    logic   walk_green;
    logic   walk_yellow;
    logic   walk_red;
    phase_t phase_now;
  } ptlc_result_t;

  function automatic logic is_blink(input phase_t p);
    return (p == PH_YELLOW) || (p == PH_YELLOW_RET) || (p == PH_BLINK) ||
           (p == PH_BLINK_BACK);
  endfunction

  function automatic logic [TICK_W-1:0] phase_length(input phase_t p, input ptlc_cfg_t c);
    logic [TICK_W-1:0] len;
    case (p)
      PH_GREEN:                 len = c.green;
      PH_YELLOW, PH_YELLOW_RET: len = c.yellow;
      PH_RED:                   len = c.red;
      PH_EXTEND, PH_WALK:       len = c.walk;
      default:                  len = c.blink;
    endcase
    return len;
  endfunction

  function automatic phase_t next_phase(input phase_t p);
    phase_t np;
    case (p)
      PH_GREEN:      np = PH_YELLOW;
      PH_YELLOW:     np = PH_RED;
      PH_RED:        np = PH_YELLOW_RET;
      PH_YELLOW_RET: np = PH_GREEN;
      PH_EXTEND:     np = PH_BLINK_BACK;
      PH_BLINK:      np = PH_WALK;
      PH_WALK:       np = PH_BLINK_BACK;
      default:       np = PH_GREEN;
    endcase
    return np;
  endfunction

endpackage

@@ hw/rtl/ptlc_if.sv @@
// Valid/ready channel interfaces for the tick input and the lamp result.
// No dependencies.
`timescale 1ns / 1ps

interface ptlc_in_if;
  logic valid;
  logic ready;
  logic pedestrian_request;

  modport source (output valid, output pedestrian_request, input ready);
  modport sink   (input valid, input pedestrian_request, output ready);
endinterface

interface ptlc_out_if;
  logic       valid;
  logic       ready;
  logic       car_green;
  logic       car_yellow;
  logic       car_red;
  logic       walk_green;
  logic       walk_yellow;
  logic       walk_red;
  logic [2:0] phase_now;

  modport source (output valid, output car_green, output car_yellow, output car_red,
                  output walk_green, output walk_yellow, output walk_red,
                  output phase_now, input ready);
  modport sink   (input valid, input car_green, input car_yellow, input car_red,
                  input walk_green, input walk_yellow, input walk_red,
                  input phase_now, output ready);
endinterface

@@ hw/rtl/ptlc_cfg_regs.sv @@
// Phase length registers written through the plain configuration port.
// Depends on ptlc_pkg.
`timescale 1ns / 1ps

module ptlc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ptlc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [ptlc_pkg::TICK_W-1:0]        cfg_wdata,
  output ptlc_pkg::ptlc_cfg_t                cfg
);
  import ptlc_pkg::*;

  ptlc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{green: RESET_TICKS, yellow: RESET_TICKS, red: RESET_TICKS,
                 walk: RESET_TICKS, blink: RESET_TICKS};
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GREEN:  cfg_r.green  <= cfg_wdata;
        CFG_YELLOW: cfg_r.yellow <= cfg_wdata;
        CFG_RED:    cfg_r.red    <= cfg_wdata;
        CFG_WALK:   cfg_r.walk   <= cfg_wdata;
        CFG_BLINK:  cfg_r.blink  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/ptlc_core.sv @@
// Tick pipeline: input register, phase/countdown update, lamp result register.
// Depends on ptlc_pkg and the channel interfaces in ptlc_if.sv.
`timescale 1ns / 1ps

module ptlc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  ptlc_pkg::ptlc_cfg_t cfg,
  ptlc_in_if.sink             in_ch,
  ptlc_out_if.source          out_ch
);
  import ptlc_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_req_r;
  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] ticks_left_r, ticks_left_nxt;
  logic              yellow_lit_r, yellow_lit_nxt;
  logic              out_valid_r, out_valid_nxt;
  ptlc_result_t      res_r, res_nxt;
  logic              adv;
  logic              in_take;
  phase_t            enter_ph;
  logic              do_enter;

  assign adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_take   = in_ch.valid && in_ch.ready;

  always_comb begin
    enter_ph = next_phase(phase_r);
    do_enter = 1'b0;
    if (s1_req_r && !phase_r[2]) begin
      enter_ph = (phase_r == PH_RED) ? PH_EXTEND : PH_BLINK;
      do_enter = 1'b1;
    end else if (ticks_left_r <= TICK_W'(1)) begin
      do_enter = 1'b1;
    end

    phase_nxt      = phase_r;
    ticks_left_nxt = ticks_left_r;
    yellow_lit_nxt = yellow_lit_r;
    if (adv) begin
      if (do_enter) begin
        phase_nxt      = enter_ph;
        ticks_left_nxt = phase_length(enter_ph, cfg);
        yellow_lit_nxt = is_blink(enter_ph);
      end else begin
        ticks_left_nxt = ticks_left_r - TICK_W'(1);
        yellow_lit_nxt = yellow_lit_r ^ is_blink(phase_r);
      end
    end

    res_nxt.car_green   = (phase_nxt == PH_GREEN);
    res_nxt.car_red     = (phase_nxt == PH_RED) || (phase_nxt == PH_EXTEND) ||
                          (phase_nxt == PH_WALK);
    res_nxt.walk_green  = res_nxt.car_red || (phase_nxt == PH_BLINK_BACK);
    res_nxt.walk_red    = (phase_nxt == PH_GREEN) || (phase_nxt == PH_BLINK);
    res_nxt.car_yellow  = is_blink(phase_nxt) && yellow_lit_nxt;
    res_nxt.walk_yellow = res_nxt.car_yellow;
    res_nxt.phase_now   = phase_nxt;

    s1_valid_nxt  = in_take || (s1_valid_r && !adv);
    out_valid_nxt = adv || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_GREEN;
      ticks_left_r <= RESET_TICKS;
      yellow_lit_r <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      phase_r      <= phase_nxt;
      ticks_left_r <= ticks_left_nxt;
      yellow_lit_r <= yellow_lit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= in_ch.pedestrian_request;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.car_green   = res_r.car_green;
  assign out_ch.car_yellow  = res_r.car_yellow;
  assign out_ch.car_red     = res_r.car_red;
  assign out_ch.walk_green  = res_r.walk_green;
  assign out_ch.walk_yellow = res_r.walk_yellow;
  assign out_ch.walk_red    = res_r.walk_red;
  assign out_ch.phase_now   = res_r.phase_now;

endmodule

@@ hw/rtl/pedestrian_traffic_light_controller.sv @@
// Pedestrian traffic light controller, one item per tick.
// Path: input reg, combinational phase/countdown update, result reg.
// Throughput: 1 item per cycle while the result channel is not stalled.
// Reset (sync, active low): phase car green, countdown 10, yellows off, all
// phase lengths 10, both channels empty.
`timescale 1ns / 1ps

module pedestrian_traffic_light_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  ptlc_in_if.sink                        in_ch,
  ptlc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ptlc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ptlc_pkg::TICK_W-1:0]    cfg_wdata
);
  import ptlc_pkg::*;

  ptlc_cfg_t cfg;

  ptlc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ptlc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

@@ hw/rtl/ptlc_checker.sv @@
// Port-level checks on the lamp result channel of the controller.
// Depends on ptlc_pkg and pedestrian_traffic_light_controller_assert.svh; bound to the top.
`timescale 1ns / 1ps
`include "pedestrian_traffic_light_controller_assert.svh"

module ptlc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       car_green,
  input logic       car_yellow,
  input logic       car_red,
  input logic       walk_green,
  input logic       walk_yellow,
  input logic       walk_red,
  input logic [2:0] phase_now
);
  import ptlc_pkg::*;

  logic       stall;
  logic [8:0] lamps;
  logic [1:0] car_lit;

  assign stall   = out_valid && !out_ready;
  assign lamps   = {car_green, car_yellow, car_red, walk_green, walk_yellow, walk_red,
                    phase_now};
  assign car_lit = 2'(car_green) + 2'(car_yellow) + 2'(car_red);

  `PTLC_ASSERT(a_out_hold, clk, rst_n, stall |=> out_valid && $stable(lamps), "ptlc: held item")
  `PTLC_ASSERT_NEVER(a_car_conflict, clk, rst_n, out_valid && car_lit > 2'd1, "ptlc: car lamps")
  `PTLC_ASSERT_NEVER(a_walk_conflict, clk, rst_n, out_valid && walk_green && walk_red, "ptlc: walk")
  `PTLC_ASSERT(a_yellow_pair, clk, rst_n, !out_valid || (car_yellow == walk_yellow), "ptlc: yellow")
  `PTLC_ASSERT(a_green_phase, clk, rst_n, !out_valid || ((phase_now == PH_GREEN) == car_green), "ptlc: green")

endmodule

bind pedestrian_traffic_light_controller ptlc_checker u_ptlc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .car_green   (out_ch.car_green),
  .car_yellow  (out_ch.car_yellow),
  .car_red     (out_ch.car_red),
  .walk_green  (out_ch.walk_green),
  .walk_yellow (out_ch.walk_yellow),
  .walk_red    (out_ch.walk_red),
  .phase_now   (out_ch.phase_now)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the pedestrian traffic light controller.
// Drives ticks through the valid/ready channels, predicts every lamp item
// in place and checks it; depends on ptlc_pkg, ptlc_if and the RTL top.
`timescale 1ns / 1ps

module testbench;
  import ptlc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned RANDOM_TICKS   = 150;
  localparam int unsigned IDX_SPAN       = 2 ** CFG_IDX_W;
  // request bits of the fast cycle, first tick in the MSB
  localparam logic [17:0] FAST_PATTERN   = 18'b110001000001100001;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [TICK_W-1:0] cfg_wdata;

  ptlc_in_if  in_if ();
  ptlc_out_if out_if ();

  pedestrian_traffic_light_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  ptlc_cfg_t   timing;
  phase_t      cur_phase;
  logic [TICK_W-1:0] count_left;
  logic        lamp_on;
  ptlc_result_t lamp_queue[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned req_pct;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  ptlc_result_t seen, want;

  function automatic logic blinking(input phase_t p);
    return (p == PH_YELLOW) || (p == PH_YELLOW_RET) || (p == PH_BLINK) ||
           (p == PH_BLINK_BACK);
  endfunction

  function automatic logic [TICK_W-1:0] dwell(input phase_t p);
    logic [TICK_W-1:0] n;
    case (p)
      PH_GREEN:                 n = timing.green;
      PH_YELLOW, PH_YELLOW_RET: n = timing.yellow;
      PH_RED:                   n = timing.red;
      PH_EXTEND, PH_WALK:       n = timing.walk;
      default:                  n = timing.blink;
    endcase
    return n;
  endfunction

  function automatic phase_t successor(input phase_t p);
    phase_t n;
    case (p)
      PH_GREEN:      n = PH_YELLOW;
      PH_YELLOW:     n = PH_RED;
      PH_RED:        n = PH_YELLOW_RET;
      PH_YELLOW_RET: n = PH_GREEN;
      PH_EXTEND:     n = PH_BLINK_BACK;
      PH_BLINK:      n = PH_WALK;
      PH_WALK:       n = PH_BLINK_BACK;
      default:       n = PH_GREEN;
    endcase
    return n;
  endfunction

  function void enter_phase(input phase_t p);
    cur_phase  = p;
    count_left = dwell(p);
    lamp_on    = blinking(p);
  endfunction

  function ptlc_result_t predict_tick(input logic req);
    ptlc_result_t r;
    logic normal;
    normal = (cur_phase == PH_GREEN) || (cur_phase == PH_YELLOW) ||
             (cur_phase == PH_RED) || (cur_phase == PH_YELLOW_RET);
    if (req && normal) begin
      enter_phase(cur_phase == PH_RED ? PH_EXTEND : PH_BLINK);
    end else if (count_left <= 1) begin
      enter_phase(successor(cur_phase));
    end else begin
      count_left = count_left - 1'b1;
      if (blinking(cur_phase)) lamp_on = ~lamp_on;
    end
    r = '0;
    case (cur_phase)
      PH_GREEN: begin
        r.car_green = 1'b1;
        r.walk_red  = 1'b1;
      end
      PH_RED, PH_EXTEND, PH_WALK: begin
        r.car_red    = 1'b1;
        r.walk_green = 1'b1;
      end
      PH_BLINK:      r.walk_red   = 1'b1;
      PH_BLINK_BACK: r.walk_green = 1'b1;
      default: ;
    endcase
    if (blinking(cur_phase)) begin
      r.car_yellow  = lamp_on;
      r.walk_yellow = lamp_on;
    end
    r.phase_now = cur_phase;
    return r;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // lamp item checker and receiver back-pressure
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen = {out_if.car_green, out_if.car_yellow, out_if.car_red, out_if.walk_green,
              out_if.walk_yellow, out_if.walk_red, out_if.phase_now};
      if (lamp_queue.size() == 0) begin
        note_error("lamp item with nothing expected");
      end else begin
        want = lamp_queue.pop_front();
        if (seen !== want)
          note_error($sformatf(
            "lamps exp g%0b y%0b r%0b wg%0b wy%0b wr%0b ph%0d got g%0b y%0b r%0b wg%0b wy%0b wr%0b ph%0d",
            want.car_green, want.car_yellow, want.car_red, want.walk_green,
            want.walk_yellow, want.walk_red, want.phase_now,
            seen.car_green, seen.car_yellow, seen.car_red, seen.walk_green,
            seen.walk_yellow, seen.walk_red, seen.phase_now));
      end
    end
    out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic req);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_if.valid              <= 1'b1;
    in_if.pedestrian_request <= req;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    lamp_queue.push_back(predict_tick(req));
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (lamp_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_GREEN:  timing.green  = val;
      CFG_YELLOW: timing.yellow = val;
      CFG_RED:    timing.red    = val;
      CFG_WALK:   timing.walk   = val;
      CFG_BLINK:  timing.blink  = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [TICK_W-1:0] g, input logic [TICK_W-1:0] y,
                           input logic [TICK_W-1:0] r, input logic [TICK_W-1:0] w,
                           input logic [TICK_W-1:0] b);
    write_reg(CFG_GREEN, g);
    write_reg(CFG_YELLOW, y);
    write_reg(CFG_RED, r);
    write_reg(CFG_WALK, w);
    write_reg(CFG_BLINK, b);
  endtask

  // shortest phases: requests from every normal phase, ignored ones in the sequence
  task automatic test_fast_cycle();
    write_all(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    for (int i = $bits(FAST_PATTERN) - 1; i >= 0; i--) send_tick(FAST_PATTERN[i]);
    settle();
  endtask

  // zero green length acts as one; unused indexes must not disturb anything
  task automatic test_zero_and_spare();
    write_reg(CFG_GREEN, 8'd0);
    for (int k = int'(CFG_BLINK) + 1; k < IDX_SPAN; k++) write_reg(CFG_IDX_W'(k), 8'hFF);
    repeat (5) send_tick(1'b0);
    send_tick(1'b1);
    settle();
  endtask

  function automatic logic [TICK_W-1:0] pick_len(input int unsigned style);
    logic [TICK_W-1:0] v;
    case (style)
      0: v = TICK_W'($urandom_range(1, 8));
      1: begin
        case ($urandom_range(0, 2))
          0: v = 8'd1;
          1: v = 8'd255;
          default: v = TICK_W'($urandom_range(0, 255));
        endcase
      end
      default: v = TICK_W'($urandom_range(1, 20));
    endcase
    return v;
  endfunction

  task automatic test_random();
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin tx_idle_pct = 22; rx_idle_pct = 73; end
        1: begin tx_idle_pct = 73; rx_idle_pct = 22; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int s = 0; s < 3; s++) begin
        settle();
        write_all(pick_len(s), pick_len(s), pick_len(s), pick_len(s), pick_len(s));
        req_pct = $urandom_range(2, 30);
        for (int n = 0; n < RANDOM_TICKS; n++)
          send_tick($urandom_range(0, 99) < req_pct);
      end
    end
    settle();
  endtask

  initial begin
    in_if.valid              = 1'b0;
    in_if.pedestrian_request = 1'b0;
    cfg_we                   = 1'b0;
    cfg_idx                  = '0;
    cfg_wdata                = '0;
    timing     = '{green: RESET_TICKS, yellow: RESET_TICKS, red: RESET_TICKS,
                   walk: RESET_TICKS, blink: RESET_TICKS};
    cur_phase  = PH_GREEN;
    count_left = RESET_TICKS;
    lamp_on    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fast_cycle();
    test_zero_and_spare();
    test_random();

    if (lamp_queue.size() != 0) note_error("lamp items still expected at end");
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
